[rtl/clksel_pkg.sv]
// ----------------------------------------------------------------------------
// clksel_pkg
// Shared constants for the clock select register block: register offsets,
// access kinds, mode selections and channel widths.
// ----------------------------------------------------------------------------
package clksel_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned OFF_W       = 12;
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 64;
   localparam int unsigned DIV_CNT_W   = 5;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

   localparam logic [OFF_W-1:0] OFF_MODE         = 12'h000;
   localparam logic [OFF_W-1:0] OFF_MODE_STATUS  = 12'h004;
   localparam logic [OFF_W-1:0] OFF_DIVISOR      = 12'h010;
   localparam logic [OFF_W-1:0] OFF_PLL_ONE      = 12'h038;
   localparam logic [OFF_W-1:0] OFF_PLL_FEEDBACK = 12'h03C;

   localparam logic [DATA_W-1:0] HI_OSC_HZ    = 32'd4000000;
   localparam logic [DATA_W-1:0] MAIN_OSC_RST = 32'd4000000;
   localparam logic [5:0]        FEEDBACK_MAX = 6'd49;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [1:0] SEL_HI_OSC  = 2'd0;
   localparam logic [1:0] SEL_MAIN    = 2'd1;
   localparam logic [1:0] SEL_PLL     = 2'd2;
   localparam logic [1:0] SEL_INVALID = 2'd3;

endpackage

[rtl/clock_select_register_block.sv]
// ----------------------------------------------------------------------------
// clock_select_register_block
// Clock control registers; a write recomputes master and base clock with a
// shared one-bit-per-cycle divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser kind, tdata offset + write data
//  rsp      out  rsp_tvalid/rsp_tready  tdata read data + base clock
//  csr      in   csr_valid/csr_ready    csr_data main oscillator hz
//
//  read or write without recompute: ST_RESULT, then the response once the output is free
//  write with recompute: ST_SELECT, ST_DIV_PLL and ST_MUL in pll mode,
//  ST_BASE_START, ST_DIV_BASE, ST_RESULT; the shared divider does both divisions
//  one request at a time; the next one is taken while a response waits
//  synchronous active-high reset, no clearing pass
// ----------------------------------------------------------------------------
module clock_select_register_block (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [11:0] byte_offset, [43:12] write_data, [47:44] zero
   input  logic [clksel_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] read_data, [63:32] base_clock_hz
   output logic [clksel_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [clksel_pkg::DATA_W-1:0]        csr_data
);
   import clksel_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_DIV_PLL,
      ST_MUL,
      ST_BASE_START,
      ST_DIV_BASE,
      ST_RESULT
   } state_type;

   state_type              state_ff, state_in;
   logic [DATA_W-1:0]      main_osc_ff, main_osc_in;
   logic [7:0]             clock_mode_ff, clock_mode_in;
   logic [1:0]             divisor_sel_ff, divisor_sel_in;
   logic [DATA_W-1:0]      pll_one_ff, pll_one_in;
   logic [5:0]             feedback_ff, feedback_in;
   logic [DATA_W-1:0]      master_ff, master_in;
   logic [DATA_W-1:0]      base_clock_ff, base_clock_in;
   logic [DATA_W-1:0]      read_data_ff, read_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [3:0]             div_rem_ff, div_rem_in;
   logic [DATA_W-1:0]      div_quo_ff, div_quo_in;
   logic [4:0]             div_den_ff, div_den_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   logic [OFF_W-1:0]       req_offset;
   logic [DATA_W-1:0]      req_wdata;
   logic                   req_fire;
   logic [4:0]             trial;
   logic [4:0]             diff;
   logic                   trial_ge;
   logic [6:0]             n_plus;
   logic [38:0]            pll_product;
   logic                   recompute;

   assign req_offset = req_tdata[OFF_W-1:0];
   assign req_wdata  = req_tdata[OFF_W+DATA_W-1:OFF_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared restoring divider step
   assign trial    = {div_rem_ff, div_quo_ff[DATA_W-1]};
   assign trial_ge = (trial >= div_den_ff);
   assign diff     = trial - div_den_ff;

   assign n_plus      = {1'b0, feedback_ff} + 7'd1;
   assign pll_product = {7'd0, div_quo_ff} * {32'd0, n_plus};

   always_comb begin
      state_in       = state_ff;
      main_osc_in    = main_osc_ff;
      clock_mode_in  = clock_mode_ff;
      divisor_sel_in = divisor_sel_ff;
      pll_one_in     = pll_one_ff;
      feedback_in    = feedback_ff;
      master_in      = master_ff;
      base_clock_in  = base_clock_ff;
      read_data_in   = read_data_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      recompute      = 1'b0;

      if (csr_valid) begin
         main_osc_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               read_data_in = '0;
               if (req_tuser == KIND_READ) begin
                  case (req_offset)
                     OFF_MODE, OFF_MODE_STATUS: read_data_in = {24'd0, clock_mode_ff};
                     OFF_DIVISOR:      read_data_in = {30'd0, divisor_sel_ff};
                     OFF_PLL_ONE:      read_data_in = pll_one_ff;
                     OFF_PLL_FEEDBACK: read_data_in = {26'd0, feedback_ff};
                     default:          read_data_in = '0;
                  endcase
               end else begin
                  case (req_offset)
                     OFF_MODE: begin
                        clock_mode_in = req_wdata[7:0];
                        recompute     = 1'b1;
                     end
                     OFF_DIVISOR: begin
                        divisor_sel_in = req_wdata[1:0];
                        recompute      = 1'b1;
                     end
                     OFF_PLL_ONE: begin
                        pll_one_in = req_wdata;
                        recompute  = 1'b1;
                     end
                     OFF_PLL_FEEDBACK: begin
                        feedback_in = req_wdata[5:0];
                        recompute   = (req_wdata[5:0] <= FEEDBACK_MAX);
                     end
                     default: recompute = 1'b0;
                  endcase
               end
               state_in = recompute ? ST_SELECT : ST_RESULT;
            end
         end
         ST_SELECT: begin
            case (clock_mode_ff[6:5])
               SEL_HI_OSC: begin
                  master_in = HI_OSC_HZ;
                  state_in  = ST_BASE_START;
               end
               SEL_MAIN: begin
                  master_in = clock_mode_ff[3] ? main_osc_ff : '0;
                  state_in  = ST_BASE_START;
               end
               SEL_PLL: begin
                  if (clock_mode_ff[4]) begin
                     div_rem_in = '0;
                     div_quo_in = main_osc_ff;
                     div_den_in = {1'b0, pll_one_ff[7:4]} + 5'd1;
                     div_cnt_in = '0;
                     state_in   = ST_DIV_PLL;
                  end else begin
                     master_in = '0;
                     state_in  = ST_BASE_START;
                  end
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_DIV_PLL, ST_DIV_BASE: begin
            div_rem_in = trial_ge ? diff[3:0] : trial[3:0];
            div_quo_in = {div_quo_ff[DATA_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = (state_ff == ST_DIV_PLL) ? ST_MUL : ST_RESULT;
               if (state_ff == ST_DIV_BASE) begin
                  base_clock_in = {div_quo_ff[DATA_W-2:0], trial_ge};
               end
            end
         end
         ST_MUL: begin
            master_in = pll_product[DATA_W-1:0];
            state_in  = ST_BASE_START;
         end
         ST_BASE_START: begin
            div_rem_in = '0;
            div_quo_in = master_ff;
            div_den_in = {3'd0, divisor_sel_ff} + 5'd1;
            div_cnt_in = '0;
            state_in   = ST_DIV_BASE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {base_clock_ff, read_data_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         main_osc_ff    <= MAIN_OSC_RST;
         clock_mode_ff  <= '0;
         divisor_sel_ff <= '0;
         pll_one_ff     <= '0;
         feedback_ff    <= '0;
         master_ff      <= HI_OSC_HZ;
         base_clock_ff  <= MAIN_OSC_RST;
         rsp_valid_ff   <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         main_osc_ff    <= main_osc_in;
         clock_mode_ff  <= clock_mode_in;
         divisor_sel_ff <= divisor_sel_in;
         pll_one_ff     <= pll_one_in;
         feedback_ff    <= feedback_in;
         master_ff      <= master_in;
         base_clock_ff  <= base_clock_in;
         rsp_valid_ff   <= rsp_valid_in;
         div_cnt_ff     <= div_cnt_in;
      end
      read_data_ff <= read_data_in;
      rsp_data_ff  <= rsp_data_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
   end

endmodule

[rtl/clksel_checker.sv]
// ----------------------------------------------------------------------------
// clksel_checker
// Port-level checks for the clock select register block, bound to the top.
// ----------------------------------------------------------------------------
module clksel_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [clksel_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import clksel_pkg::*;

   // idle and empty right after reset
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // read answers through ST_RESULT after accept when the output is free
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_READ) && !rsp_tvalid)
         |-> ##2 rsp_tvalid)
      else $error("read response late");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind clock_select_register_block clksel_checker u_clksel_checker (.*);

[tb/tb_clock_select_register_block.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_select_register_block
// Self-checking bench for the clock select register block. Read and write
// requests go in from a queue with random gaps, responses are drained with
// random stalls and one long hold-off, and every response is checked against
// an in-bench model of the registers and the master and base clock math.
// The main oscillator setting is changed between phases while the block is
// idle, covering its extremes.
// ----------------------------------------------------------------------------
module tb_clock_select_register_block;
   import clksel_pkg::*;

   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES = 100;

   typedef struct packed {
      logic              kind;
      logic [OFF_W-1:0]  offset;
      logic [DATA_W-1:0] data;
   } access_t;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] base_hz;
   } clk_rsp_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [DATA_W-1:0]      csr_data = '0;

   access_t  request_queue[$];
   clk_rsp_t expected_rsp[$];
   access_t  cur_req;

   // register model
   logic [7:0]        mode_q    = 8'd0;
   logic [1:0]        div_q     = 2'd0;
   logic [31:0]       pll_one_q = 32'd0;
   logic [5:0]        fb_q      = 6'd0;
   logic [DATA_W-1:0] master_q  = HI_OSC_HZ;
   logic [DATA_W-1:0] base_q    = MAIN_OSC_RST;
   logic [DATA_W-1:0] osc_q     = MAIN_OSC_RST;

   int unsigned errors       = 0;
   int unsigned accepted_cnt = 0;
   int unsigned hold_left    = 0;
   int unsigned stall_cnt    = 0;
   logic        hold_done    = 1'b0;
   logic        calm         = 1'b0;

   clock_select_register_block DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic predict_access(input access_t a);
      logic [DATA_W-1:0] rd;
      logic              recalc;
      logic [DATA_W-1:0] k_div;
      logic [DATA_W-1:0] n_mul;
      rd = '0;
      recalc = 1'b0;
      if (a.kind == KIND_READ) begin
         case (a.offset)
            OFF_MODE, OFF_MODE_STATUS: rd = {24'd0, mode_q};
            OFF_DIVISOR:               rd = {30'd0, div_q};
            OFF_PLL_ONE:               rd = pll_one_q;
            OFF_PLL_FEEDBACK:          rd = {26'd0, fb_q};
            default:                   rd = '0;
         endcase
      end else begin
         case (a.offset)
            OFF_MODE: begin
               mode_q = a.data[7:0];
               recalc = 1'b1;
            end
            OFF_DIVISOR: begin
               div_q = a.data[1:0];
               recalc = 1'b1;
            end
            OFF_PLL_ONE: begin
               pll_one_q = a.data;
               recalc = 1'b1;
            end
            OFF_PLL_FEEDBACK: begin
               fb_q = a.data[5:0];
               recalc = (fb_q <= FEEDBACK_MAX);
            end
            default: recalc = 1'b0;
         endcase
      end
      if (recalc && mode_q[6:5] != SEL_INVALID) begin
         k_div = {28'd0, pll_one_q[7:4]} + 32'd1;
         n_mul = {26'd0, fb_q} + 32'd1;
         case (mode_q[6:5])
            SEL_HI_OSC: master_q = HI_OSC_HZ;
            SEL_MAIN:   master_q = mode_q[3] ? osc_q : '0;
            default:    master_q = mode_q[4] ? (osc_q / k_div) * n_mul : '0;
         endcase
         // divide by 1..4, truncating
         base_q = master_q / ({30'd0, div_q} + 32'd1);
      end
      expected_rsp.push_back('{read_data: rd, base_hz: base_q});
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_access(cur_req);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
               cur_req = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'd0, cur_req.data, cur_req.offset};
               req_tuser  <= cur_req.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready with random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && accepted_cnt >= 300) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 23);
      end
   end

   // response checker
   always @(posedge clock) begin
      clk_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report($sformatf("response with no request outstanding, data %h", rsp_tdata));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[31:0] !== want.read_data)
               report($sformatf("read_data %h, expected %h", rsp_tdata[31:0], want.read_data));
            if (rsp_tdata[63:32] !== want.base_hz)
               report($sformatf("base_clock_hz %0d, expected %0d",
                                rsp_tdata[63:32], want.base_hz));
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   task automatic add_req(input logic kind, input logic [OFF_W-1:0] off,
                          input logic [DATA_W-1:0] data);
      request_queue.push_back('{kind: kind, offset: off, data: data});
   endtask

   task automatic add_random_req();
      access_t     a;
      int unsigned pick;
      pick     = $urandom_range(99);
      a.kind   = ($urandom_range(99) < 60) ? KIND_WRITE : KIND_READ;
      a.data   = $urandom;
      case (pick % 5)
         0: a.offset = OFF_MODE;
         1: a.offset = OFF_MODE_STATUS;
         2: a.offset = OFF_DIVISOR;
         3: a.offset = OFF_PLL_ONE;
         default: a.offset = OFF_PLL_FEEDBACK;
      endcase
      if (pick >= 80)
         a.offset = 12'($urandom_range(4095));
      // steer most mode writes to a valid selection, most with both enable bits set
      if (a.kind == KIND_WRITE && a.offset == OFF_MODE && $urandom_range(3) != 0) begin
         a.data[6:5] = 2'($urandom_range(2));
         if ($urandom_range(3) != 0)
            a.data[4:3] = 2'b11;
      end
      if (a.kind == KIND_WRITE && a.offset == OFF_PLL_FEEDBACK && $urandom_range(3) != 0)
         a.data[5:0] = 6'($urandom_range(49));
      request_queue.push_back(a);
   endtask

   // checked between edges so that the driver's updates have settled
   task automatic wait_drained(input int unsigned extra);
      do @(negedge clock);
      while (request_queue.size() != 0 || req_tvalid || expected_rsp.size() != 0);
      @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_main_osc(input logic [DATA_W-1:0] hz);
      wait_drained(DRAIN_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= hz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      osc_q = hz;
   endtask

   task automatic random_phase(input int unsigned count);
      repeat (count) add_random_req();
      wait_drained(0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values and unknown offset
      add_req(KIND_READ,  OFF_MODE,         32'd0);
      add_req(KIND_READ,  OFF_MODE_STATUS,  32'hFFFF_FFFF);
      add_req(KIND_READ,  OFF_DIVISOR,      32'd0);
      add_req(KIND_READ,  OFF_PLL_ONE,      32'd0);
      add_req(KIND_READ,  OFF_PLL_FEEDBACK, 32'd0);
      add_req(KIND_READ,  12'hFFF,          32'd0);
      // divisor, main oscillator and pll modes
      add_req(KIND_WRITE, OFF_DIVISOR,      32'hFFFF_FFFF);
      add_req(KIND_WRITE, OFF_MODE,         32'h0000_0028);
      add_req(KIND_WRITE, OFF_MODE,         32'h0000_0020);
      add_req(KIND_WRITE, OFF_PLL_ONE,      32'hFFFF_FFFF);
      add_req(KIND_WRITE, OFF_PLL_FEEDBACK, 32'd49);
      add_req(KIND_WRITE, OFF_MODE,         32'h0000_0050);
      // feedback above limit is stored without recompute
      add_req(KIND_WRITE, OFF_PLL_FEEDBACK, 32'd50);
      add_req(KIND_WRITE, OFF_PLL_FEEDBACK, 32'hFFFF_FFFF);
      add_req(KIND_READ,  OFF_PLL_FEEDBACK, 32'd0);
      add_req(KIND_WRITE, OFF_MODE,         32'h0000_0040);
      // invalid selection
      add_req(KIND_WRITE, OFF_MODE,         32'hFFFF_FFFF);
      add_req(KIND_READ,  OFF_MODE,         32'd0);
      add_req(KIND_WRITE, OFF_DIVISOR,      32'd2);
      // writes that hit nothing, then mode and divisor back to reset values
      add_req(KIND_WRITE, OFF_MODE_STATUS,  32'h1234_5678);
      add_req(KIND_WRITE, 12'hFFF,          32'hFFFF_FFFF);
      add_req(KIND_WRITE, OFF_MODE,         32'd0);
      add_req(KIND_WRITE, OFF_DIVISOR,      32'd1);
      add_req(KIND_WRITE, OFF_DIVISOR,      32'd0);
      add_req(KIND_READ,  OFF_DIVISOR,      32'd0);
      wait_drained(0);

      set_main_osc(32'd1);
      random_phase(120);

      set_main_osc(32'hFFFF_FFFF);
      calm = 1'b1;
      random_phase(150);
      calm = 1'b0;

      set_main_osc($urandom);
      random_phase(150);

      set_main_osc(MAIN_OSC_RST);
      random_phase(150);

      wait_drained(DRAIN_CYCLES);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
